// File: hw/rtl/seg_pkg.sv
// shared types, widths and status codes for the segment intersection pipeline
// no dependencies
package seg_pkg;

   localparam int COORD_BITS          = 16;
   localparam int PARAM_FRAC_BITS_DEF = 16;
   localparam int DIFF_BITS           = COORD_BITS + 1;

   typedef enum logic [2:0] {
      STATUS_PARALLEL   = 3'd0,
      STATUS_COINCIDENT = 3'd1,
      STATUS_OUTSIDE_A  = 3'd2,
      STATUS_OUTSIDE_B  = 3'd3,
      STATUS_INTERSECT  = 3'd4
   } status_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] a_start_x;
      logic signed [COORD_BITS-1:0] a_start_y;
      logic signed [COORD_BITS-1:0] a_start_z;
      logic signed [COORD_BITS-1:0] a_end_x;
      logic signed [COORD_BITS-1:0] a_end_y;
      logic signed [COORD_BITS-1:0] a_end_z;
      logic signed [COORD_BITS-1:0] b_start_x;
      logic signed [COORD_BITS-1:0] b_start_y;
      logic signed [COORD_BITS-1:0] b_end_x;
      logic signed [COORD_BITS-1:0] b_end_y;
   } req_type;

   typedef struct packed {
      logic                         hit;
      logic [2:0]                   status;
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic signed [COORD_BITS-1:0] point_z;
   } rsp_type;

   // difference of two coordinates, exact
   function automatic logic signed [DIFF_BITS-1:0] coord_diff(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b);
      coord_diff = DIFF_BITS'(a) - DIFF_BITS'(b);
   endfunction

endpackage

// File: hw/rtl/seg_div.sv
// pipelined restoring divider, one quotient bit per stage, side data carried along
// self-contained, sized entirely through its parameters
module seg_div #(
   parameter int NUM_W  = 35,
   parameter int Q_W    = 17,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [NUM_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [Q_W-1:0]    out_quot,
   output logic [SIDE_W-1:0] out_side
);

   logic [NUM_W:0]    rem_ff  [Q_W];
   logic [NUM_W:0]    den_ff  [Q_W];
   logic [Q_W-1:0]    quot_ff [Q_W];
   logic [SIDE_W-1:0] side_ff [Q_W];
   logic              vld_ff  [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic [NUM_W:0]    rem_in;
      logic [NUM_W:0]    den_in;
      logic [Q_W-1:0]    quot_in;
      logic [NUM_W:0]    trial;
      logic [NUM_W:0]    den_prev;
      logic [Q_W-1:0]    quot_prev;
      logic [SIDE_W-1:0] side_prev;
      logic              vld_prev;

      if (k == 0) begin : g_first
         assign trial     = {1'b0, in_num};
         assign den_prev  = {1'b0, in_den};
         assign quot_prev = '0;
         assign side_prev = in_side;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign trial     = {rem_ff[k-1][NUM_W-1:0], 1'b0};
         assign den_prev  = den_ff[k-1];
         assign quot_prev = {quot_ff[k-1][Q_W-2:0], 1'b0};
         assign side_prev = side_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
      end

      always_comb begin
         den_in  = den_prev;
         quot_in = quot_prev;
         rem_in  = trial;
         if (trial >= den_in) begin
            rem_in     = trial - den_in;
            quot_in[0] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_in;
            quot_ff[k] <= quot_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[Q_W-1];
   assign out_quot  = quot_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

endmodule

// File: hw/rtl/segment_intersection_2d.sv
// top level of the 2d segment intersection pipeline
// depends on seg_pkg and seg_div
//
// One transaction per clock while no result is held, fully pipelined; the stages are
// four stages for differences, cross products, numerators and classification,
// PARAM_FRAC_BITS + 1 divider stages, two stages for the interpolation multiply and
// the output register. The divider, one restoring step per stage, sets the depth.
// The whole pipeline holds while a result waits with rsp_stall high; req_stall
// follows that condition, so nothing is lost or repeated. Status is parallel,
// coincident (a hit with no point), outside A, outside B or intersect; the point
// on A, z included, is zero unless the status is intersect.
module segment_intersection_2d
   import seg_pkg::*;
#(
   parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int C_W    = COORD_BITS;
   localparam int D_W    = DIFF_BITS;
   localparam int P_W    = 2 * D_W;
   localparam int N_W    = P_W + 1;
   localparam int Q_W    = PARAM_FRAC_BITS + 1;
   localparam int M_W    = Q_W + 1 + D_W;
   localparam int SIDE_W = 3 + 3 * C_W + 3 * D_W;

   // whole pipeline moves unless a finished result is held off
   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // stage 1: differences
   logic                  s1_vld_ff;
   logic signed [D_W-1:0] dax_ff, day_ff, daz_ff, dbx_ff, dby_ff, wx_ff, wy_ff;
   logic signed [C_W-1:0] s1_sx_ff, s1_sy_ff, s1_sz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dax_ff   <= coord_diff(req_data.a_end_x, req_data.a_start_x);
         day_ff   <= coord_diff(req_data.a_end_y, req_data.a_start_y);
         daz_ff   <= coord_diff(req_data.a_end_z, req_data.a_start_z);
         dbx_ff   <= coord_diff(req_data.b_end_x, req_data.b_start_x);
         dby_ff   <= coord_diff(req_data.b_end_y, req_data.b_start_y);
         wx_ff    <= coord_diff(req_data.a_start_x, req_data.b_start_x);
         wy_ff    <= coord_diff(req_data.a_start_y, req_data.b_start_y);
         s1_sx_ff <= req_data.a_start_x;
         s1_sy_ff <= req_data.a_start_y;
         s1_sz_ff <= req_data.a_start_z;
      end
   end

   // stage 2: the six cross products
   logic                  s2_vld_ff;
   logic signed [P_W-1:0] p_ff [6];
   logic signed [D_W-1:0] s2_dx_ff, s2_dy_ff, s2_dz_ff;
   logic signed [C_W-1:0] s2_sx_ff, s2_sy_ff, s2_sz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (advance) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff[0]  <= dax_ff * dby_ff;
         p_ff[1]  <= day_ff * dbx_ff;
         p_ff[2]  <= wy_ff * dbx_ff;
         p_ff[3]  <= wx_ff * dby_ff;
         p_ff[4]  <= wy_ff * dax_ff;
         p_ff[5]  <= wx_ff * day_ff;
         s2_dx_ff <= dax_ff;
         s2_dy_ff <= day_ff;
         s2_dz_ff <= daz_ff;
         s2_sx_ff <= s1_sx_ff;
         s2_sy_ff <= s1_sy_ff;
         s2_sz_ff <= s1_sz_ff;
      end
   end

   // stage 3: denominator and numerators
   logic                  s3_vld_ff;
   logic signed [N_W-1:0] den_ff, ns_ff, nt_ff;
   logic signed [D_W-1:0] s3_dx_ff, s3_dy_ff, s3_dz_ff;
   logic signed [C_W-1:0] s3_sx_ff, s3_sy_ff, s3_sz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (advance) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         den_ff   <= N_W'(p_ff[0]) - N_W'(p_ff[1]);
         ns_ff    <= N_W'(p_ff[2]) - N_W'(p_ff[3]);
         nt_ff    <= N_W'(p_ff[4]) - N_W'(p_ff[5]);
         s3_dx_ff <= s2_dx_ff;
         s3_dy_ff <= s2_dy_ff;
         s3_dz_ff <= s2_dz_ff;
         s3_sx_ff <= s2_sx_ff;
         s3_sy_ff <= s2_sy_ff;
         s3_sz_ff <= s2_sz_ff;
      end
   end

   // stage 4: classification and magnitudes for the divider
   logic [N_W-1:0] abs_den, abs_ns, abs_nt;
   logic           out_s, out_t;
   status_type     status_in;

   always_comb begin
      abs_den = den_ff[N_W-1] ? N_W'(-den_ff) : N_W'(den_ff);
      abs_ns  = ns_ff[N_W-1]  ? N_W'(-ns_ff)  : N_W'(ns_ff);
      abs_nt  = nt_ff[N_W-1]  ? N_W'(-nt_ff)  : N_W'(nt_ff);
      // parameter outside [0,1]: signs disagree, or magnitude beyond the denominator
      out_s = ((ns_ff != '0) && (ns_ff[N_W-1] != den_ff[N_W-1])) || (abs_ns > abs_den);
      out_t = ((nt_ff != '0) && (nt_ff[N_W-1] != den_ff[N_W-1])) || (abs_nt > abs_den);
      if (den_ff == '0) begin
         status_in = STATUS_PARALLEL;
      end else if (ns_ff == '0) begin
         status_in = STATUS_COINCIDENT;
      end else if (out_s) begin
         status_in = STATUS_OUTSIDE_A;
      end else if (out_t) begin
         status_in = STATUS_OUTSIDE_B;
      end else begin
         status_in = STATUS_INTERSECT;
      end
   end

   logic              s4_vld_ff;
   logic [N_W-1:0]    s4_num_ff, s4_den_ff;
   logic [SIDE_W-1:0] s4_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (advance) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_num_ff  <= abs_ns;
         s4_den_ff  <= abs_den;
         s4_side_ff <= {status_in, s3_sx_ff, s3_sy_ff, s3_sz_ff,
                        s3_dx_ff, s3_dy_ff, s3_dz_ff};
      end
   end

   // divider: s as an unsigned fraction, truncated
   logic              dv_vld;
   logic [Q_W-1:0]    dv_quot;
   logic [SIDE_W-1:0] dv_side;

   seg_div #(
      .NUM_W  (N_W),
      .Q_W    (Q_W),
      .SIDE_W (SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s4_vld_ff),
      .in_num    (s4_num_ff),
      .in_den    (s4_den_ff),
      .in_side   (s4_side_ff),
      .out_valid (dv_vld),
      .out_quot  (dv_quot),
      .out_side  (dv_side)
   );

   logic [2:0]            dv_status;
   logic signed [C_W-1:0] dv_sx, dv_sy, dv_sz;
   logic signed [D_W-1:0] dv_dx, dv_dy, dv_dz;
   logic signed [Q_W:0]   sq;

   assign {dv_status, dv_sx, dv_sy, dv_sz, dv_dx, dv_dy, dv_dz} = dv_side;
   assign sq = {1'b0, dv_quot};

   // interpolation multiply
   logic                  l1_vld_ff;
   logic signed [M_W-1:0] mx_ff, my_ff, mz_ff;
   logic signed [C_W-1:0] l1_sx_ff, l1_sy_ff, l1_sz_ff;
   logic [2:0]            l1_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_vld_ff <= 1'b0;
      end else if (advance) begin
         l1_vld_ff <= dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mx_ff        <= sq * dv_dx;
         my_ff        <= sq * dv_dy;
         mz_ff        <= sq * dv_dz;
         l1_sx_ff     <= dv_sx;
         l1_sy_ff     <= dv_sy;
         l1_sz_ff     <= dv_sz;
         l1_status_ff <= dv_status;
      end
   end

   // start plus the product scaled down, truncated toward zero
   function automatic logic [C_W-1:0] lerp(input logic signed [C_W-1:0] start,
                                           input logic signed [M_W-1:0] prod);
      logic [M_W-1:0] mag;
      logic [M_W-1:0] step;
      logic [M_W-1:0] sum;
      mag  = prod[M_W-1] ? M_W'(-prod) : M_W'(prod);
      step = mag >> PARAM_FRAC_BITS;
      step = prod[M_W-1] ? M_W'(-step) : step;
      sum  = M_W'(start) + step;
      lerp = sum[C_W-1:0];
   endfunction

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    is_hit;
   logic    is_int;

   assign is_int = (l1_status_ff == STATUS_INTERSECT);
   assign is_hit = is_int || (l1_status_ff == STATUS_COINCIDENT);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= l1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.hit     <= is_hit;
         rsp_data_ff.status  <= l1_status_ff;
         rsp_data_ff.point_x <= is_int ? lerp(l1_sx_ff, mx_ff) : '0;
         rsp_data_ff.point_y <= is_int ? lerp(l1_sy_ff, my_ff) : '0;
         rsp_data_ff.point_z <= is_int ? lerp(l1_sz_ff, mz_ff) : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hw/rtl/seg_checker.sv
// port-level checks on the segment intersection top level, with its bind
// depends on seg_pkg and segment_intersection_2d
module seg_checker
   import seg_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("held result changed");

   a_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.hit == (rsp_data.status == STATUS_COINCIDENT ||
                                     rsp_data.status == STATUS_INTERSECT))
      else $error("hit disagrees with status");

   a_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_INTERSECT |->
         rsp_data.point_x == '0 && rsp_data.point_y == '0 && rsp_data.point_z == '0)
      else $error("point not zero without intersection");

   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with no held result");

endmodule

bind segment_intersection_2d seg_checker u_seg_checker (.*);
